>>> rtl/core/dspm_pkg.sv
// Shared types and constants for the dot-star pattern matcher.
package dspm_pkg;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_TEXT  = 2'd2;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h2E;

	typedef struct packed {
		logic       load;
		logic       start;
		logic       text;
		logic [7:0] symbol;
	} cmd_t;

endpackage

>>> rtl/core/dspm_units.sv
// Pattern unit store: unit bytes, repeat flags, unit count and overflow flag.
module dspm_units #(
	parameter int MAX_UNITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dspm_pkg::cmd_t                cmd,
	output logic [MAX_UNITS-1:0][7:0]     unit_byte,
	output logic [MAX_UNITS-1:0]          unit_repeat,
	output logic [$clog2(MAX_UNITS+1)-1:0] unit_count,
	output logic                          overflow_seen
);
	import dspm_pkg::*;

	localparam int CW = $clog2(MAX_UNITS + 1);

	logic [MAX_UNITS-1:0][7:0] unit_byte_q;
	logic [MAX_UNITS-1:0]      unit_repeat_q;
	logic [CW-1:0]             unit_count_q;
	logic                      overflow_q;
	logic                      text_phase_q;

	logic [CW-1:0] eff_count;
	logic          eff_ovf;
	logic          last_rep;
	logic          star_ext;
	logic          full;
	logic          wr_lit;
	logic          set_star;
	logic          set_ovf;

	// The first pattern byte after any start or text clears the old pattern.
	always_comb begin
		eff_count = text_phase_q ? '0 : unit_count_q;
		eff_ovf   = !text_phase_q && overflow_q;
		last_rep  = 1'b0;
		for (int i = 0; i < MAX_UNITS; i++) begin
			if (eff_count == CW'(i + 1)) begin
				last_rep = unit_repeat_q[i];
			end
		end
		star_ext = (cmd.symbol == STAR_BYTE) && (eff_count != '0) && !last_rep;
		full     = eff_count >= CW'(MAX_UNITS);
		wr_lit   = cmd.load && !eff_ovf && !star_ext && !full;
		set_star = cmd.load && !eff_ovf && star_ext;
		set_ovf  = cmd.load && !eff_ovf && !star_ext && full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_count_q <= '0;
			overflow_q   <= 1'b0;
			text_phase_q <= 1'b0;
		end else if (cmd.load) begin
			text_phase_q <= 1'b0;
			unit_count_q <= wr_lit ? eff_count + CW'(1) : eff_count;
			overflow_q   <= eff_ovf || set_ovf;
		end else if (cmd.start || cmd.text) begin
			text_phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_UNITS; i++) begin
			if (wr_lit && eff_count == CW'(i)) begin
				unit_byte_q[i]   <= cmd.symbol;
				unit_repeat_q[i] <= 1'b0;
			end
			if (set_star && eff_count == CW'(i + 1)) begin
				unit_repeat_q[i] <= 1'b1;
			end
		end
	end

	assign unit_byte     = unit_byte_q;
	assign unit_repeat   = unit_repeat_q;
	assign unit_count    = unit_count_q;
	assign overflow_seen = overflow_q;

endmodule

>>> rtl/core/dspm_nfa.sv
// Active-position vector with repeat closure and one-byte advance.
module dspm_nfa #(
	parameter int MAX_UNITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dspm_pkg::cmd_t                 cmd,
	input  logic [MAX_UNITS-1:0][7:0]      unit_byte,
	input  logic [MAX_UNITS-1:0]           unit_repeat,
	input  logic [$clog2(MAX_UNITS+1)-1:0] unit_count,
	output logic                           match
);
	import dspm_pkg::*;

	localparam int CW = $clog2(MAX_UNITS + 1);
	localparam int PW = MAX_UNITS + 1;

	logic [PW-1:0]        active_q;
	logic [MAX_UNITS-1:0] live;
	logic [MAX_UNITS-1:0] hit;
	logic [PW-1:0]        src;
	logic [PW-1:0]        c1;
	logic [PW-1:0]        adv;
	logic [PW-1:0]        c2;
	logic [PW-1:0]        nxt;

	always_comb begin
		for (int i = 0; i < MAX_UNITS; i++) begin
			live[i] = CW'(i) < unit_count;
		end
		src = cmd.start ? PW'(1) : active_q;

		// A live position on a repeatable unit may also skip past it.
		c1 = src;
		for (int i = 0; i < MAX_UNITS; i++) begin
			if (c1[i] && unit_repeat[i] && live[i]) begin
				c1[i + 1] = 1'b1;
			end
		end

		adv = '0;
		for (int i = 0; i < MAX_UNITS; i++) begin
			hit[i] = c1[i] && live[i] &&
				(unit_byte[i] == ANY_BYTE || unit_byte[i] == cmd.symbol);
			if (hit[i]) begin
				if (unit_repeat[i]) begin
					adv[i] = 1'b1;
				end else begin
					adv[i + 1] = 1'b1;
				end
			end
		end

		c2 = adv;
		for (int i = 0; i < MAX_UNITS; i++) begin
			if (c2[i] && unit_repeat[i] && live[i]) begin
				c2[i + 1] = 1'b1;
			end
		end

		nxt   = cmd.start ? c1 : c2;
		match = nxt[unit_count];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= PW'(1);
		end else if (cmd.load) begin
			active_q <= PW'(1);
		end else if (cmd.start || cmd.text) begin
			active_q <= nxt;
		end
	end

endmodule

>>> rtl/core/dot_star_pattern_matcher.sv
// Top level of the dot-star pattern matcher: input stage, unit store, matcher, result register.
// A start or text transaction is registered in the input stage, then its result in the result
// register. Throughput: one transaction per cycle while the result register is free; the cycle holds the
// repeat closure chain over all unit positions, twice, around the one-byte advance. Pattern
// bytes and unused codes give no result.
// Reset (arst_n low, asynchronous) empties the pattern, clears the overflow flag,
// sets the active positions to position zero and drops any pending transaction.
module dot_star_pattern_matcher #(
	parameter int MAX_UNITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       matched,
	output logic       pattern_overflow
);
	import dspm_pkg::*;

	localparam int CW = $clog2(MAX_UNITS + 1);

	logic       valid_s1;
	logic [1:0] action_s1;
	logic [7:0] symbol_s1;

	logic out_valid_q;
	logic matched_q;
	logic overflow_q;

	logic emits;
	logic out_free;
	logic fire_s1;
	cmd_t cmd;

	logic [MAX_UNITS-1:0][7:0] unit_byte;
	logic [MAX_UNITS-1:0]      unit_repeat;
	logic [CW-1:0]             unit_count;
	logic                      overflow_seen;
	logic                      match;

	always_comb begin
		emits      = valid_s1 && (action_s1 == ACT_START || action_s1 == ACT_TEXT);
		out_free   = !out_valid_q || out_ready;
		fire_s1    = valid_s1 && (!emits || out_free);
		in_ready   = !valid_s1 || fire_s1;
		cmd.load   = fire_s1 && action_s1 == ACT_LOAD;
		cmd.start  = fire_s1 && action_s1 == ACT_START;
		cmd.text   = fire_s1 && action_s1 == ACT_TEXT;
		cmd.symbol = symbol_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			symbol_s1 <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && emits) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Start and text leave the overflow flag unchanged, so its current value is reported.
	always_ff @(posedge clk) begin
		if (fire_s1 && emits) begin
			matched_q  <= match;
			overflow_q <= overflow_seen;
		end
	end

	dspm_units #(
		.MAX_UNITS(MAX_UNITS)
	) u_units (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.unit_byte    (unit_byte),
		.unit_repeat  (unit_repeat),
		.unit_count   (unit_count),
		.overflow_seen(overflow_seen)
	);

	dspm_nfa #(
		.MAX_UNITS(MAX_UNITS)
	) u_nfa (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.unit_byte  (unit_byte),
		.unit_repeat(unit_repeat),
		.unit_count (unit_count),
		.match      (match)
	);

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = overflow_q;

endmodule

>>> rtl/core/dspm_checker.sv
// Port-level assertions for the dot-star pattern matcher, bound to its top level.
module dspm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] action,
	input logic       out_valid,
	input logic       out_ready,
	input logic       matched,
	input logic       pattern_overflow
);
	import dspm_pkg::*;

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(pattern_overflow))
		else $error("result changed while stalled");

	// With the result register free, the input side never stalls.
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while result register free");

	// A new result follows an accepted transaction.
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an accepted transaction");

	// Only start and text transactions produce results.
	a_result_action: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(action == ACT_START || action == ACT_TEXT, 2))
		else $error("result from a transaction that gives none");

endmodule

bind dot_star_pattern_matcher dspm_checker u_dspm_checker (.*);
